// File: hw/rtl/fcc_pkg.sv
// Shared types and constants for the RGB565 frame clip and convert block.
package fcc_pkg;

  // Input operation codes
  localparam logic [1:0] OP_PAL_WR = 2'd0;
  localparam logic [1:0] OP_PIXEL  = 2'd1;
  localparam logic [1:0] OP_REPEAT = 2'd2;

  // Source pixel formats
  localparam logic [1:0] FMT_RGB565   = 2'd0;
  localparam logic [1:0] FMT_PAL8     = 2'd1;
  localparam logic [1:0] FMT_RGB1555  = 2'd2;
  localparam logic [1:0] FMT_XRGB8888 = 2'd3;

  // Configuration register indexes
  localparam int          CFG_IDX_W    = 3;
  localparam int          CFG_DATA_W   = 12;
  localparam logic [2:0]  CFG_MODE_W   = 3'd0;
  localparam logic [2:0]  CFG_MODE_H   = 3'd1;
  localparam logic [2:0]  CFG_SRC_W    = 3'd2;
  localparam logic [2:0]  CFG_SRC_H    = 3'd3;
  localparam logic [2:0]  CFG_FORMAT   = 3'd4;
  localparam logic [2:0]  CFG_PAL_LEN  = 3'd5;

  // Result word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BELL  = 1'b1;

  // Fallback view geometry
  localparam int DEF_W = 320;
  localparam int DEF_H = 240;

  // Field widths
  localparam int ADDR_W   = 18;
  localparam int FRAME_W  = 30;
  localparam int PIX_W    = 32;
  localparam int COLOR_W  = 16;
  localparam int PAL_IDX_W = 8;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_LEN_W = 9;

  // Decoupling queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Configuration registers
  typedef struct packed {
    logic [11:0]          mode_w;
    logic [11:0]          mode_h;
    logic [10:0]          src_w;
    logic [10:0]          src_h;
    logic [1:0]           fmt;
    logic [PAL_LEN_W-1:0] pal_len;
  } cfg_t;

  // One classified item waiting for the back end
  typedef struct packed {
    logic                 has_pix;
    logic                 has_bell;
    logic                 buf_sel;
    logic [FRAME_W-1:0]   frame;
    logic [ADDR_W-1:0]    row_base;
    logic [ADDR_W-1:0]    col_off;
    logic [PIX_W-1:0]     pix;
    logic [COLOR_W-1:0]   pal_data;
    logic                 pal_hit;
  } q_entry_t;

  // Back end phase for items with two results
  typedef enum logic {
    PH_PIX,
    PH_BELL
  } phase_e;

endpackage

// File: hw/rtl/fcc_front.sv
// Front end: accepts words, runs the raster counters, reads the palette, classifies pixels.
module fcc_front import fcc_pkg::*; #(
  parameter int MAX_VIEW_WIDTH  = 512,
  parameter int MAX_VIEW_HEIGHT = 512,
  parameter int MAX_SOURCE_SIDE = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic [PIX_W-1:0]     pixel_value_i,
  input  logic [PAL_IDX_W-1:0] palette_index_i,
  input  logic [COLOR_W-1:0]   palette_color_i,
  output logic                 push_o,
  output q_entry_t             push_data_o,
  input  logic                 q_full_i
);

  localparam int SS_W  = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int VW_W  = $clog2(MAX_VIEW_WIDTH + 1);
  localparam int VH_W  = $clog2(MAX_VIEW_HEIGHT + 1);
  localparam int M1_W  = (SS_W > VW_W) ? SS_W : VW_W;
  localparam int M2_W  = (M1_W > VH_W) ? M1_W : VH_W;
  localparam int GW    = ((M2_W > 10) ? M2_W : 10) + 1;
  localparam int CNT_W = $clog2(MAX_SOURCE_SIDE);

  // Source side clamp: zero becomes one, oversize becomes the maximum
  function automatic logic [GW-1:0] clamp_side(input logic [10:0] v);
    logic [GW-1:0] e;
    e = GW'(v);
    if (e == '0) begin
      return GW'(1);
    end else if (e > GW'(MAX_SOURCE_SIDE)) begin
      return GW'(MAX_SOURCE_SIDE);
    end
    return e;
  endfunction

  // ---------------- geometry, registered from the config ----------------
  logic [GW-1:0]     vw, vh, pitch, sw, sh, cw, ch, dx, dy, sx, sy;
  logic              view_ok;
  logic [GW-1:0]     sx_q, sy_q, sx_end_q, sy_end_q;
  logic [ADDR_W-1:0] pitch_q, dxs_q, dys_q;

  always_comb begin
    view_ok = (cfg_i.mode_w != '0) && ({1'b0, cfg_i.mode_w} <= 13'(MAX_VIEW_WIDTH)) &&
              (cfg_i.mode_h != '0) && ({1'b0, cfg_i.mode_h} <= 13'(MAX_VIEW_HEIGHT));
    if (view_ok) begin
      vw    = GW'(cfg_i.mode_w);
      vh    = GW'(cfg_i.mode_h);
      pitch = (vw + GW'(3)) & ~GW'(3);
    end else begin
      vw    = GW'(DEF_W);
      vh    = GW'(DEF_H);
      pitch = GW'(DEF_W);
    end
    sw = clamp_side(cfg_i.src_w);
    sh = clamp_side(cfg_i.src_h);
    cw = (sw < vw) ? sw : vw;
    ch = (sh < vh) ? sh : vh;
    dx = (vw - cw) >> 1;
    dy = (vh - ch) >> 1;
    sx = (sw - cw) >> 1;
    sy = (sh - ch) >> 1;
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= sx;
    sy_q     <= sy;
    sx_end_q <= sx + cw;
    sy_end_q <= sy + ch;
    pitch_q  <= ADDR_W'(pitch);
    dxs_q    <= ADDR_W'(dx) - ADDR_W'(sx);
    dys_q    <= ADDR_W'(dy) - ADDR_W'(sy);
  end

  // ---------------- handshake through stages A and B ----------------
  logic a_vld_q, a_vld_d, b_vld_q, b_vld_d;
  logic a_go, b_go, b_free, a_free, accept;
  logic has_pix, has_bell, in_win;

  assign b_go       = b_vld_q && !q_full_i;
  assign b_free     = !b_vld_q || b_go;
  assign a_go       = a_vld_q && b_free;
  assign a_free     = !a_vld_q || a_go;
  assign in_stall_o = !a_free;
  assign accept     = in_valid_i && a_free;
  assign push_o     = b_go;

  // ---------------- raster counters and frame state ----------------
  logic [CNT_W-1:0]   col_q, row_q, col_d, row_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               act_buf_q, act_buf_d, last_pub_q, last_pub_d;
  logic               end_row, end_frame;
  logic               acc_pix, acc_rep;

  assign acc_pix = accept && (op_i == OP_PIXEL);
  assign acc_rep = accept && (op_i == OP_REPEAT);

  always_comb begin
    end_row    = (GW'(col_q) + GW'(1)) >= sw;
    end_frame  = end_row && ((GW'(row_q) + GW'(1)) >= sh);
    col_d      = col_q;
    row_d      = row_q;
    frame_d    = frame_q;
    act_buf_d  = act_buf_q;
    last_pub_d = last_pub_q;
    if (acc_pix) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_frame ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
      if (end_frame) begin
        frame_d    = frame_q + FRAME_W'(1);
        last_pub_d = act_buf_q;
        act_buf_d  = !act_buf_q;
      end
    end else if (acc_rep) begin
      frame_d = frame_q + FRAME_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      frame_q    <= '0;
      act_buf_q  <= 1'b0;
      last_pub_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      frame_q    <= frame_d;
      act_buf_q  <= act_buf_d;
      last_pub_q <= last_pub_d;
    end
  end

  // ---------------- palette memory with per-entry valid bits ----------------
  logic [COLOR_W-1:0]   pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] pal_vld_q;
  logic [COLOR_W-1:0]   a_pal_q;
  logic                 a_hit_q;
  logic                 pal_wr;

  assign pal_wr = accept && (op_i == OP_PAL_WR);

  always_ff @(posedge clk_i) begin
    if (pal_wr) begin
      pal_mem[palette_index_i] <= palette_color_i;
    end
    if (acc_pix) begin
      a_pal_q <= pal_mem[pixel_value_i[PAL_IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      a_hit_q   <= 1'b0;
    end else begin
      if (pal_wr) begin
        pal_vld_q[palette_index_i] <= 1'b1;
      end
      if (acc_pix) begin
        a_hit_q <= pal_vld_q[pixel_value_i[PAL_IDX_W-1:0]];
      end
    end
  end

  // ---------------- stage A: captured word ----------------
  logic               a_is_pix_q, a_end_frame_q, a_buf_q;
  logic [CNT_W-1:0]   a_col_q, a_row_q;
  logic [FRAME_W-1:0] a_frame_q;
  logic [PIX_W-1:0]   a_pix_q;

  always_comb begin
    a_vld_d = a_vld_q;
    if (acc_pix || acc_rep) begin
      a_vld_d = 1'b1;
    end else if (a_go) begin
      a_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_pix || acc_rep) begin
      a_is_pix_q    <= acc_pix;
      a_end_frame_q <= end_frame;
      a_buf_q       <= acc_pix ? act_buf_q : last_pub_q;
      a_col_q       <= col_q;
      a_row_q       <= row_q;
      a_frame_q     <= frame_d;
      a_pix_q       <= pixel_value_i;
    end
  end

  // ---------------- stage B: clip test and row base ----------------
  logic [ADDR_W-1:0]   row_off;
  logic [2*ADDR_W-1:0] prod;
  q_entry_t            b_q;

  always_comb begin
    in_win   = (GW'(a_col_q) >= sx_q) && (GW'(a_col_q) < sx_end_q) &&
               (GW'(a_row_q) >= sy_q) && (GW'(a_row_q) < sy_end_q);
    has_pix  = a_is_pix_q && in_win;
    has_bell = !a_is_pix_q || a_end_frame_q;
    row_off  = ADDR_W'(a_row_q) + dys_q;
    prod     = row_off * pitch_q;
    b_vld_d  = b_vld_q;
    if (b_free) begin
      b_vld_d = a_vld_q && (has_pix || has_bell);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_q.has_pix  <= has_pix;
      b_q.has_bell <= has_bell;
      b_q.buf_sel  <= a_buf_q;
      b_q.frame    <= a_frame_q;
      b_q.row_base <= prod[ADDR_W-1:0];
      b_q.col_off  <= ADDR_W'(a_col_q) + dxs_q;
      b_q.pix      <= a_pix_q;
      b_q.pal_data <= a_pal_q;
      b_q.pal_hit  <= a_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      b_vld_q <= b_vld_d;
    end
  end

  assign push_data_o = b_q;

endmodule

// File: hw/rtl/fcc_queue.sv
// Short FIFO between the classifying front end and the result back end.
module fcc_queue import fcc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     empty_o
);

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

// File: hw/rtl/fcc_back.sv
// Back end: converts pixels to RGB565 and emits pixel and doorbell result words.
module fcc_back import fcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_entry_t           head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic               buffer_select_o,
  output logic [ADDR_W-1:0]  write_address_o,
  output logic [COLOR_W-1:0] pixel_565_o,
  output logic [PIX_W-1:0]   doorbell_word_o,
  output logic               last_o
);

  phase_e ph_q, ph_d;
  logic   out_free, emit_pix, emit_bell, out_vld_q;
  logic [COLOR_W-1:0] conv;
  logic [PIX_W-1:0]   v;
  logic               pal_ok;

  assign out_free = !out_vld_q || !out_stall_i;

  // Format conversion of the head word
  always_comb begin
    v      = head_i.pix;
    pal_ok = head_i.pal_hit && ({1'b0, v[PAL_IDX_W-1:0]} < cfg_i.pal_len);
    case (cfg_i.fmt)
      FMT_RGB565:   conv = v[15:0];
      FMT_PAL8:     conv = pal_ok ? head_i.pal_data : '0;
      FMT_RGB1555:  conv = {v[14:10], v[9:5], v[9], v[4:0]};
      FMT_XRGB8888: conv = {v[23:19], v[15:10], v[7:3]};
      default:      conv = '0;
    endcase
  end

  // Next phase
  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PH_PIX: begin
        if (emit_pix && head_i.has_bell) begin
          ph_d = PH_BELL;
        end
      end
      PH_BELL: begin
        if (emit_bell) begin
          ph_d = PH_PIX;
        end
      end
      default: ph_d = PH_PIX;
    endcase
  end

  // Emit decisions
  always_comb begin
    emit_pix  = 1'b0;
    emit_bell = 1'b0;
    case (ph_q)
      PH_PIX: begin
        emit_pix  = out_free && !empty_i && head_i.has_pix;
        emit_bell = out_free && !empty_i && !head_i.has_pix;
      end
      PH_BELL: begin
        emit_bell = out_free && !empty_i;
      end
      default: ;
    endcase
    pop_o = emit_bell || (emit_pix && !head_i.has_bell);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_PIX;
      out_vld_q <= 1'b0;
    end else begin
      ph_q <= ph_d;
      if (emit_pix || emit_bell) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (emit_pix) begin
      kind_o          <= KIND_PIXEL;
      buffer_select_o <= head_i.buf_sel;
      write_address_o <= head_i.row_base + head_i.col_off;
      pixel_565_o     <= conv;
      doorbell_word_o <= '0;
      last_o          <= !head_i.has_bell;
    end else if (emit_bell) begin
      kind_o          <= KIND_BELL;
      buffer_select_o <= head_i.buf_sel;
      write_address_o <= '0;
      pixel_565_o     <= '0;
      doorbell_word_o <= {head_i.frame, 1'b0, head_i.buf_sel};
      last_o          <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;

  a_bell_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_BELL) |-> (!empty_i && head_i.has_bell))
    else $error("doorbell phase without a doorbell at the queue head");

  a_bell_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_bell |=> (out_valid_o && kind_o == KIND_BELL && last_o))
    else $error("doorbell word not marked last");

endmodule

// File: hw/rtl/frame_clip_convert_rgb565_top.sv
// A result word passes stages A and B, the queue and the output register; a doorbell after a
// pixel write follows it out of the same queue entry. Throughput: one input word per cycle
// unless stalled; a frame end pixel inside the clip window yields two result words in turn.
// Reset: config returns to defaults, raster counters, frame count and buffer selects clear,
// and palette valid bits clear at once, so every palette entry reads zero until written.
// Configuration is held in this module; the front and back ends read it directly.
module frame_clip_convert_rgb565_top import fcc_pkg::*; #(
  parameter int MAX_VIEW_WIDTH  = 512,
  parameter int MAX_VIEW_HEIGHT = 512,
  parameter int MAX_SOURCE_SIDE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic [PAL_IDX_W-1:0]  palette_index_i,
  input  logic [COLOR_W-1:0]    palette_color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  kind_o,
  output logic                  buffer_select_o,
  output logic [ADDR_W-1:0]     write_address_o,
  output logic [COLOR_W-1:0]    pixel_565_o,
  output logic [PIX_W-1:0]      doorbell_word_o,
  output logic                  last_o
);

  cfg_t     cfg_q;
  logic     push, q_full, pop, q_empty;
  q_entry_t push_data, head;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_w  <= 12'(DEF_W);
      cfg_q.mode_h  <= 12'(DEF_H);
      cfg_q.src_w   <= 11'(DEF_W);
      cfg_q.src_h   <= 11'(DEF_H);
      cfg_q.fmt     <= FMT_RGB565;
      cfg_q.pal_len <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE_W:  cfg_q.mode_w  <= cfg_wdata_i;
        CFG_MODE_H:  cfg_q.mode_h  <= cfg_wdata_i;
        CFG_SRC_W:   cfg_q.src_w   <= cfg_wdata_i[10:0];
        CFG_SRC_H:   cfg_q.src_h   <= cfg_wdata_i[10:0];
        CFG_FORMAT:  cfg_q.fmt     <= cfg_wdata_i[1:0];
        CFG_PAL_LEN: cfg_q.pal_len <= cfg_wdata_i[PAL_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  fcc_front #(
    .MAX_VIEW_WIDTH  (MAX_VIEW_WIDTH),
    .MAX_VIEW_HEIGHT (MAX_VIEW_HEIGHT),
    .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .pixel_value_i   (pixel_value_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .q_full_i        (q_full)
  );

  fcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (q_empty)
  );

  fcc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .empty_i         (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .buffer_select_o (buffer_select_o),
    .write_address_o (write_address_o),
    .pixel_565_o     (pixel_565_o),
    .doorbell_word_o (doorbell_word_o),
    .last_o          (last_o)
  );

endmodule
